[hw/rtl/spb_pkg.sv]
// Shared types, constants and arithmetic helpers for the subpicture RGB565 blend unit.
// Used by spb_cfg, spb_locate, spb_mix and subpicture_rgb565_blend_unit.
package spb_pkg;

  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned PALETTE_SIZE = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned PIXEL_W      = 16;
  localparam int unsigned CODE_W       = 4;
  localparam int unsigned LEVEL_W      = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'hf;
  localparam logic [11:0]        DIV15_RECIP = 12'd2185;  // ceil(2^15 / 15)
  localparam int unsigned        DIV15_SHIFT = 15;

  localparam logic [12:0] FRAME_WIDTH_RST = 13'd720;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_WINDOW_LEFT    = 3'd1,
    CFG_WINDOW_TOP     = 3'd2,
    CFG_WINDOW_COLUMNS = 3'd3,
    CFG_WINDOW_ROWS    = 3'd4,
    CFG_SLOT_MAP       = 3'd5,
    CFG_OPACITY_MAP    = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [11:0] window_left;
    logic [11:0] window_top;
    logic [12:0] window_columns;
    logic [12:0] window_rows;
    logic [63:0] slot_map;
    logic [63:0] opacity_map;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [PIXEL_W-1:0] colour;
    logic [LEVEL_W-1:0] level;
    logic               blend;
    logic               in_win;
  } blend_req_t;

  function automatic logic [PIXEL_W-1:0] palette(input logic [CODE_W-1:0] slot);
    logic [PIXEL_W-1:0] c;
    case (slot)
      4'd0:    c = 16'h0000;
      4'd1:    c = 16'h20e2;
      4'd2:    c = 16'h83ac;
      4'd3:    c = 16'h4227;
      4'd4:    c = 16'ha381;
      4'd5:    c = 16'had13;
      4'd6:    c = 16'hbdf8;
      4'd7:    c = 16'hd657;
      4'd8:    c = 16'hee67;
      4'd9:    c = 16'h6a40;
      4'd10:   c = 16'hd4c1;
      4'd11:   c = 16'hf602;
      4'd12:   c = 16'hf664;
      4'd13:   c = 16'he561;
      4'd14:   c = 16'had13;
      default: c = 16'hffdf;
    endcase
    return c;
  endfunction

  // (f*(15-o) + c*o) / 15 on one colour field; divide by reciprocal, exact for sums < 1024
  function automatic logic [5:0] mix_field(input logic [5:0] f, input logic [5:0] c,
                                           input logic [LEVEL_W-1:0] o);
    logic [9:0]  sum;
    logic [21:0] prod;
    sum  = ({4'b0, f} * {6'b0, LEVEL_MAX - o}) + ({4'b0, c} * {6'b0, o});
    prod = {12'b0, sum} * {10'b0, DIV15_RECIP};
    return prod[DIV15_SHIFT+5:DIV15_SHIFT];
  endfunction

endpackage

[hw/rtl/subpicture_rgb565_blend_unit.sv]
// Subpicture overlay blend on an RGB565 pixel stream (top level).
// Input requests pass a window/palette lookup register, then a mix output register;
// throughput 1 pixel per cycle while out_ready_i does not hold the output.
// Reset: position counters to 0, pipeline empty, config registers to their reset values.
// Depends on spb_pkg, spb_cfg, spb_locate and spb_mix.
module subpicture_rgb565_blend_unit #(
  parameter int unsigned COORD_BITS = spb_pkg::COORD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [spb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [spb_pkg::PIXEL_W-1:0]     frame_pixel_i,
  input  logic [spb_pkg::CODE_W-1:0]      overlay_code_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [spb_pkg::PIXEL_W-1:0]     out_pixel_o,
  output logic                            in_window_o
);

  spb_pkg::cfg_t       cfg;
  spb_pkg::blend_req_t req;
  logic                req_valid, req_ready;

  spb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spb_locate #(
    .COORD_BITS (COORD_BITS)
  ) u_locate (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_pixel_i  (frame_pixel_i),
    .overlay_code_i (overlay_code_i),
    .frame_start_i  (frame_start_i),
    .req_valid_o    (req_valid),
    .req_ready_i    (req_ready),
    .req_o          (req)
  );

  spb_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .in_window_o (in_window_o)
  );

  // input side stalls only when both stages are full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && req_valid))
    else $error("input stalled with free pipeline space");

  // a code is only blended inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid |-> (!req.blend || req.in_win))
    else $error("blend request outside window");

  // pass-through requests reach the output unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready && !req.blend) |=> (out_valid_o && out_pixel_o == $past(req.pixel)))
    else $error("pass-through pixel altered");

  // a request that moves to the output register carries its window flag along
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> (in_window_o == $past(req.in_win)))
    else $error("window flag lost");

endmodule

[hw/rtl/spb_cfg.sv]
// Configuration register file for the subpicture blend unit.
// Depends on spb_pkg for the register index codes and the cfg_t layout.
module spb_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output spb_pkg::cfg_t                     cfg_o
);

  spb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (spb_pkg::cfg_index_e'(cfg_index_i))
        spb_pkg::CFG_FRAME_WIDTH:    cfg_d.frame_width    = cfg_data_i[12:0];
        spb_pkg::CFG_WINDOW_LEFT:    cfg_d.window_left    = cfg_data_i[11:0];
        spb_pkg::CFG_WINDOW_TOP:     cfg_d.window_top     = cfg_data_i[11:0];
        spb_pkg::CFG_WINDOW_COLUMNS: cfg_d.window_columns = cfg_data_i[12:0];
        spb_pkg::CFG_WINDOW_ROWS:    cfg_d.window_rows    = cfg_data_i[12:0];
        spb_pkg::CFG_SLOT_MAP:       cfg_d.slot_map       = cfg_data_i;
        spb_pkg::CFG_OPACITY_MAP:    cfg_d.opacity_map    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{frame_width:    spb_pkg::FRAME_WIDTH_RST,
                 window_left:    '0,
                 window_top:     '0,
                 window_columns: '0,
                 window_rows:    '0,
                 slot_map:       '0,
                 opacity_map:    '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/spb_locate.sv]
// Raster position counters, window test and palette lookup; registers one blend request.
// Depends on spb_pkg for cfg_t, blend_req_t and the palette table.
module spb_locate #(
  parameter int unsigned COORD_BITS = spb_pkg::COORD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spb_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [spb_pkg::PIXEL_W-1:0]     frame_pixel_i,
  input  logic [spb_pkg::CODE_W-1:0]      overlay_code_i,
  input  logic                            frame_start_i,
  output logic                            req_valid_o,
  input  logic                            req_ready_i,
  output spb_pkg::blend_req_t             req_o
);

  localparam int unsigned CW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [COORD_BITS-1:0] col_eff, row_eff;
  logic [CW-1:0]         col_ext, row_ext, left_ext, top_ext;
  logic                  accept, win_hit, row_end;
  logic [spb_pkg::CODE_W-1:0]  slot;
  logic [spb_pkg::LEVEL_W-1:0] level;
  logic                  req_valid_q, req_valid_d;
  spb_pkg::blend_req_t   req_q, req_d;

  assign in_ready_o = !req_valid_q || req_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign col_eff  = frame_start_i ? '0 : col_q;
  assign row_eff  = frame_start_i ? '0 : row_q;
  assign col_ext  = CW'(col_eff);
  assign row_ext  = CW'(row_eff);
  assign left_ext = CW'(cfg_i.window_left);
  assign top_ext  = CW'(cfg_i.window_top);

  assign win_hit = (col_ext >= left_ext) &&
                   ((col_ext - left_ext) < CW'(cfg_i.window_columns)) &&
                   (row_ext >= top_ext) &&
                   ((row_ext - top_ext) < CW'(cfg_i.window_rows));

  assign row_end = ((col_ext + CW'(1)) >= CW'(cfg_i.frame_width)) || (&col_eff);

  assign slot  = cfg_i.slot_map[{overlay_code_i, 2'b00} +: spb_pkg::CODE_W];
  assign level = cfg_i.opacity_map[{overlay_code_i, 2'b00} +: spb_pkg::LEVEL_W];

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    req_d       = req_q;
    req_valid_d = req_valid_q;
    if (req_ready_i) begin
      req_valid_d = 1'b0;
    end
    if (accept) begin
      req_valid_d  = 1'b1;
      req_d.pixel  = frame_pixel_i;
      req_d.colour = spb_pkg::palette(slot);
      req_d.level  = level;
      req_d.in_win = win_hit;
      req_d.blend  = win_hit && (overlay_code_i != '0);
      if (row_end) begin
        col_d = '0;
        row_d = row_eff + COORD_BITS'(1);
      end else begin
        col_d = col_eff + COORD_BITS'(1);
        row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      req_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

endmodule

[hw/rtl/spb_mix.sv]
// Per-field RGB565 mix of frame pixel and palette colour, with the output register.
// Depends on spb_pkg for blend_req_t and mix_field.
module spb_mix (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  spb_pkg::blend_req_t             req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [spb_pkg::PIXEL_W-1:0]     out_pixel_o,
  output logic                            in_window_o
);

  logic                        out_valid_q, out_valid_d;
  logic [spb_pkg::PIXEL_W-1:0] pixel_q, pixel_d;
  logic                        in_window_q, in_window_d;
  logic                        load;
  logic [5:0]                  red, green, blue;
  logic [spb_pkg::PIXEL_W-1:0] mixed;

  assign req_ready_o = !out_valid_q || out_ready_i;
  assign load        = req_valid_i && req_ready_o;

  assign red   = spb_pkg::mix_field({1'b0, req_i.pixel[15:11]}, {1'b0, req_i.colour[15:11]},
                                    req_i.level);
  assign green = spb_pkg::mix_field(req_i.pixel[10:5], req_i.colour[10:5], req_i.level);
  assign blue  = spb_pkg::mix_field({1'b0, req_i.pixel[4:0]}, {1'b0, req_i.colour[4:0]},
                                    req_i.level);
  assign mixed = {red[4:0], green, blue[4:0]};

  always_comb begin
    out_valid_d = out_valid_q;
    pixel_d     = pixel_q;
    in_window_d = in_window_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      pixel_d     = req_i.blend ? mixed : req_i.pixel;
      in_window_d = req_i.in_win;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q     <= pixel_d;
    in_window_q <= in_window_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = pixel_q;
  assign in_window_o = in_window_q;

endmodule
